>>> rtl/core/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared widths, register indexes and field types of the volume sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

    // Field widths
    localparam int ADDR_W  = 15;   // cell address, store depth is 2**ADDR_W
    localparam int DATA_W  = 32;   // Q16.16 cell and sample values
    localparam int POS_W   = 16;   // Q2.14 world coordinate
    localparam int CFG_W   = 6;    // grid size registers
    localparam int CIDX_W  = 2;    // register index
    localparam int FRAC_W  = 14;   // blend fraction
    localparam int T_W     = 23;   // signed grid coordinate, Q.15
    localparam int TC_W    = 21;   // clamped coordinate, unsigned Q.15
    localparam int NXY_W   = 2 * CFG_W;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_GRID_X = 2'd0;
    localparam logic [CIDX_W-1:0] REG_GRID_Y = 2'd1;
    localparam logic [CIDX_W-1:0] REG_GRID_Z = 2'd2;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic        [ADDR_W-1:0] addr_t;
    typedef logic        [FRAC_W-1:0] frac_t;
    typedef logic        [CFG_W-1:0]  cell_t;

endpackage

>>> rtl/core/tvs_if.sv
// ----------------------------------------------------------------------------
// tvs_req_if / tvs_rsp_if
// Valid/ready channels: write or query requests in, samples out.
// ----------------------------------------------------------------------------
interface tvs_req_if
    import tvs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic        [ADDR_W-1:0] cell_index;
    logic signed [DATA_W-1:0] cell_value;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;

    modport source (output valid, kind, cell_index, cell_value, pos_x, pos_y, pos_z,
                    input ready);
    modport sink   (input valid, kind, cell_index, cell_value, pos_x, pos_y, pos_z,
                    output ready);
endinterface

interface tvs_rsp_if
    import tvs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample_value;

    modport source (output valid, sample_value, input ready);
    modport sink   (input valid, sample_value, output ready);
endinterface

>>> rtl/core/tvs_ram.sv
// ----------------------------------------------------------------------------
// tvs_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> rtl/core/trilinear_volume_sampler.sv
// ----------------------------------------------------------------------------
// trilinear_volume_sampler
// Grid store loaded by write requests; query requests return a trilinear
// sample of the eight cells around a Q2.14 world position.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req.valid/req.ready  kind, cell_index, cell_value, pos_x/y/z
//  rsp      out  rsp.valid/rsp.ready  sample_value
//  cfg      in   cfg_we               cfg_index, cfg_data
//
//  One request per cycle while the pipe is not stalled; queries return samples in order.
//  Stages: map, clamp, row bases, store read (4 dual-port copies), x, y, z blend.
//  Writes reach the store in the read stage, so later queries see them in order.
//  A full output register not taken by rsp.ready stalls the whole pipe; rst_n clears
//  the valid bits and sets the size registers to 32 only; the store is undefined until written.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler
    import tvs_pkg::*;
#(
    parameter int MAX_GRID_DIM = 32,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    tvs_req_if.sink           req,
    tvs_rsp_if.source         rsp,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int SW_EFF = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;

    // Size register clamped to 2 .. MAX_GRID_DIM
    function automatic cell_t eff_size(input cell_t r);
        cell_t n;
        n = r;
        if (r < CFG_W'(2))
            n = CFG_W'(2);
        else if (int'(r) > MAX_GRID_DIM)
            n = CFG_W'(MAX_GRID_DIM);
        return n;
    endfunction

    // world * maxdim + size * 2**14
    function automatic logic signed [T_W-1:0] map_t(input logic signed [POS_W-1:0] p,
                                                    input cell_t n, input cell_t m);
        logic signed [T_W-1:0] pp;
        logic signed [T_W-1:0] mm;
        logic signed [T_W-1:0] nn;
        pp = T_W'(p);
        mm = $signed(T_W'(m));
        nn = $signed(T_W'({n, {FRAC_W{1'b0}}}));
        return pp * mm + nn;
    endfunction

    // Clamp to 0 .. (size-2) * 2**15
    function automatic logic [TC_W-1:0] clamp_t(input logic signed [T_W-1:0] t,
                                                input cell_t n);
        logic [TC_W-1:0] hi;
        logic [TC_W-1:0] r;
        hi = {n - CFG_W'(2), {(TC_W-CFG_W){1'b0}}};
        if (t < 0)
            r = '0;
        else if (t > $signed({2'b00, hi}))
            r = hi;
        else
            r = t[TC_W-1:0];
        return r;
    endfunction

    // a + floor((b - a) * f / 2**14)
    function automatic sample_t blend(input sample_t a, input sample_t b, input frac_t f);
        logic signed [DATA_W:0]     d;
        logic signed [DATA_W+15:0]  pr;
        logic signed [DATA_W+15:0]  s;
        d  = (DATA_W+1)'(b) - (DATA_W+1)'(a);
        pr = (DATA_W+16)'(d) * $signed((DATA_W+16)'(f));
        s  = (DATA_W+16)'(a) + (pr >>> FRAC_W);
        return s[DATA_W-1:0];
    endfunction

    // Configuration
    cell_t              size_x_reg, size_y_reg, size_z_reg;
    logic [NXY_W-1:0]   nxy_reg;
    cell_t              nx, ny, nz, max_dim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= CFG_W'(32);
            size_y_reg <= CFG_W'(32);
            size_z_reg <= CFG_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_X: size_x_reg <= cfg_data;
                REG_GRID_Y: size_y_reg <= cfg_data;
                REG_GRID_Z: size_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        nx = eff_size(size_x_reg);
        ny = eff_size(size_y_reg);
        nz = eff_size(size_z_reg);
        max_dim = nx;
        if (ny > max_dim)
            max_dim = ny;
        if (nz > max_dim)
            max_dim = nz;
    end

    // Plane size, registered from the effective x and y sizes
    always_ff @(posedge clk)
    begin
        nxy_reg <= NXY_W'(nx) * NXY_W'(ny);
    end

    // Pipeline control: everything moves when the output slot frees
    logic adv;
    assign adv       = !rsp.valid || rsp.ready;
    assign req.ready = adv;

    // Valid bits
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;

    // Stage payloads
    logic                  s1_kind_reg, s2_kind_reg, s3_kind_reg;
    addr_t                 s1_idx_reg, s2_idx_reg, s3_idx_reg;
    sample_t               s1_val_reg, s2_val_reg, s3_val_reg;
    logic signed [T_W-1:0] s1_tx_reg, s1_ty_reg, s1_tz_reg;
    cell_t                 s2_cx_reg, s2_cy_reg, s2_cz_reg;
    frac_t                 s2_fx_reg, s2_fy_reg, s2_fz_reg;
    cell_t                 s3_cx_reg;
    addr_t                 s3_yb_reg, s3_zb_reg;
    frac_t                 s3_fx_reg, s3_fy_reg, s3_fz_reg;
    frac_t                 s4_fx_reg, s4_fy_reg, s4_fz_reg;
    sample_t               s5_c_reg [4];
    frac_t                 s5_fy_reg, s5_fz_reg;
    sample_t               s6_c0_reg, s6_c1_reg;
    frac_t                 s6_fz_reg;
    sample_t               s7_r_reg;

    logic [TC_W-1:0] tcx, tcy, tcz;
    assign tcx = clamp_t(s1_tx_reg, nx);
    assign tcy = clamp_t(s1_ty_reg, ny);
    assign tcz = clamp_t(s1_tz_reg, nz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= req.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg && (s3_kind_reg == KIND_QUERY);
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
        end
    end

    // Store: four copies, one per (dy, dz) row pair, each reads x0 and x0+1
    addr_t   rd_base [4];
    sample_t rd_a [4];
    sample_t rd_b [4];
    logic    st_we;

    assign st_we = adv && s3_v_reg && (s3_kind_reg == KIND_WRITE);

    always_comb
    begin
        rd_base[0] = s3_zb_reg + s3_yb_reg + ADDR_W'(s3_cx_reg);
        rd_base[1] = rd_base[0] + ADDR_W'(nx);
        rd_base[2] = rd_base[0] + ADDR_W'(nxy_reg);
        rd_base[3] = rd_base[1] + ADDR_W'(nxy_reg);
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_store
        tvs_ram #(
            .WIDTH (DATA_W),
            .DEPTH (1 << ADDR_W)
        ) u_ram (
            .clk     (clk),
            .we      (st_we),
            .waddr   (s3_idx_reg),
            .wdata   (s3_val_reg),
            .re      (adv),
            .raddr_a (rd_base[k]),
            .raddr_b (rd_base[k] + ADDR_W'(1)),
            .rdata_a (rd_a[k]),
            .rdata_b (rd_b[k])
        );
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // map to grid space
            s1_kind_reg <= req.kind;
            s1_idx_reg  <= req.cell_index;
            s1_val_reg  <= DATA_W'($signed(req.cell_value[SW_EFF-1:0]));
            s1_tx_reg   <= map_t(req.pos_x, nx, max_dim);
            s1_ty_reg   <= map_t(req.pos_y, ny, max_dim);
            s1_tz_reg   <= map_t(req.pos_z, nz, max_dim);
            // clamp, split cell and fraction
            s2_kind_reg <= s1_kind_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_val_reg  <= s1_val_reg;
            s2_cx_reg   <= tcx[TC_W-1:TC_W-CFG_W];
            s2_cy_reg   <= tcy[TC_W-1:TC_W-CFG_W];
            s2_cz_reg   <= tcz[TC_W-1:TC_W-CFG_W];
            s2_fx_reg   <= tcx[FRAC_W:1];
            s2_fy_reg   <= tcy[FRAC_W:1];
            s2_fz_reg   <= tcz[FRAC_W:1];
            // row and plane bases
            s3_kind_reg <= s2_kind_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_val_reg  <= s2_val_reg;
            s3_cx_reg   <= s2_cx_reg;
            s3_yb_reg   <= ADDR_W'(s2_cy_reg) * ADDR_W'(nx);
            s3_zb_reg   <= ADDR_W'(s2_cz_reg) * ADDR_W'(nxy_reg);
            s3_fx_reg   <= s2_fx_reg;
            s3_fy_reg   <= s2_fy_reg;
            s3_fz_reg   <= s2_fz_reg;
            // store read in flight
            s4_fx_reg   <= s3_fx_reg;
            s4_fy_reg   <= s3_fy_reg;
            s4_fz_reg   <= s3_fz_reg;
            // x blends
            for (int k = 0; k < 4; k++)
            begin
                s5_c_reg[k] <= blend(rd_a[k], rd_b[k], s4_fx_reg);
            end
            s5_fy_reg   <= s4_fy_reg;
            s5_fz_reg   <= s4_fz_reg;
            // y blends
            s6_c0_reg   <= blend(s5_c_reg[0], s5_c_reg[1], s5_fy_reg);
            s6_c1_reg   <= blend(s5_c_reg[2], s5_c_reg[3], s5_fy_reg);
            s6_fz_reg   <= s5_fz_reg;
            // z blend into output register
            s7_r_reg    <= blend(s6_c0_reg, s6_c1_reg, s6_fz_reg);
        end
    end

    assign rsp.valid        = s7_v_reg;
    assign rsp.sample_value = s7_r_reg;

`ifndef SYNTHESIS
    // a write never produces a sample
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s3_v_reg && (s3_kind_reg == KIND_WRITE) |=> !s4_v_reg)
        else $error("write request produced a result");

    // a stall freezes the valid bits of the store read and the x and y blend stages
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s5_v_reg) && $stable(s6_v_reg) && $stable(s4_v_reg))
        else $error("pipeline moved during a stall");

    // a bubble stays a bubble
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !s6_v_reg |=> !s7_v_reg)
        else $error("sample appeared from an empty stage");
`endif

endmodule
